// ===== rtl/salru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg: shared types and constants of the LRU cache tag tracker.
// Holds payload structs, access and outcome codes, register indexes.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ADDR_W  = 64;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_INSTR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_FILL   = 2'd1,
    OUT_EVICT  = 2'd2,
    OUT_IGNORE = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_WAYS_USED   = 2'd1,
    REG_OFFSET_BITS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DECIDE,
    BK_CLEAR
  } bk_state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_item_t;

  // Classified access as handed from front to back.
  typedef struct packed {
    logic              instr;
    logic              modify;
    logic [ADDR_W-1:0] tag;
    logic [11:0]       set;
  } acc_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/salru_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_front: access classifier.
// Splits the address into tag and set and registers the classified access.
// ----------------------------------------------------------------------------
module salru_front import salru_pkg::*; #(
  parameter int SET_W = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_item_t   item,
  input  logic [2:0] set_bits,
  input  logic [5:0] offset_bits,
  output logic       acc_valid,
  output acc_t       acc,
  input  logic       acc_pop
);

  logic       acc_valid_r, acc_valid_nxt;
  acc_t       acc_r, acc_nxt;
  logic [3:0] sb;
  logic [6:0] tshift;
  logic [ADDR_W-1:0] shifted;

  // Clamp the set width and form tag and set index.
  always_comb begin
    sb = (32'(set_bits) > SET_W) ? 4'(SET_W) : {1'b0, set_bits};
    tshift = 7'(offset_bits) + 7'(sb);
    shifted = item.address >> offset_bits;
    acc_nxt.instr  = (item.mode == MODE_INSTR);
    acc_nxt.modify = (item.mode == MODE_MODIFY);
    acc_nxt.tag    = (tshift >= 7'd64) ? '0 : (item.address >> tshift);
    acc_nxt.set    = 12'(shifted[11:0] & ((12'd1 << sb) - 12'd1));
  end

  // One-entry queue toward the back part.
  always_comb begin
    acc_valid_nxt = acc_valid_r;
    if (acc_pop) acc_valid_nxt = 1'b0;
    if (take)    acc_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else begin
      acc_valid_r <= acc_valid_nxt;
    end
    if (take) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_valid = acc_valid_r;
  assign acc       = acc_r;

endmodule

// ===== rtl/salru_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_back: tag store and replacement engine.
// Reads one set, compares, picks a way, writes back unless it is an instruction fetch, and reports.
// ----------------------------------------------------------------------------
module salru_back import salru_pkg::*; #(
  parameter int SET_W = 6,
  parameter int WAYS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] ways_used,
  input  logic       acc_valid,
  input  acc_t       acc,
  output logic       acc_pop,
  output logic       busy,
  output logic       res_valid,
  output out_item_t  res
);

  localparam int SETS = 1 << SET_W;
  localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NWW  = $clog2(WAYS + 1);
  localparam int VW   = (SET_W > 0) ? SET_W : 1;

  typedef logic [WAYS-1:0][ADDR_W-1:0] row_t;

  // Tag, stamp and valid memories, one row per set.
  row_t tag_mem [SETS];
  row_t stamp_mem [SETS];
  logic [WAYS-1:0] valid_mem [SETS];

  row_t tag_rd_r, stamp_rd_r;
  logic [WAYS-1:0] valid_rd_r;
  bk_state_t state_r, state_nxt;
  acc_t cur_r;
  logic [ADDR_W-1:0] time_r;
  logic [CNT_W-1:0] hit_r, miss_r, evict_r;
  logic [CNT_W-1:0] hit_nxt, miss_nxt, evict_nxt;
  logic res_valid_r, res_valid_nxt;
  out_item_t res_r, res_nxt;
  logic [VW-1:0] set_idx;
  logic [VW-1:0] clr_r, clr_nxt;
  logic clr_en;
  logic [NWW-1:0] nw;
  logic hit, have_empty;
  logic [WW-1:0] hit_way, empty_way, lru_way, victim;
  logic [ADDR_W-1:0] lru_stamp;
  logic wr_en;
  logic [WW-1:0] wr_way;
  logic [ADDR_W-1:0] time_nxt;

  assign set_idx = VW'(cur_r.set);

  // Clamp ways in use.
  always_comb begin
    if (ways_used == 4'd0) nw = NWW'(1);
    else if (32'(ways_used) > WAYS) nw = NWW'(WAYS);
    else nw = NWW'(ways_used);
  end

  // Way search over the registered row.
  always_comb begin
    hit = 1'b0; hit_way = '0; have_empty = 1'b0; empty_way = '0;
    lru_way = '0; lru_stamp = stamp_rd_r[0];
    for (int w = 0; w < WAYS; w++) begin
      if (w < 32'(nw)) begin
        if (!hit && valid_rd_r[w] && tag_rd_r[w] == cur_r.tag) begin
          hit = 1'b1; hit_way = WW'(w);
        end
        if (!valid_rd_r[w]) begin
          have_empty = 1'b1; empty_way = WW'(w);
        end
        if (stamp_rd_r[w] < lru_stamp) begin
          lru_stamp = stamp_rd_r[w]; lru_way = WW'(w);
        end
      end
    end
    victim = have_empty ? empty_way : lru_way;
  end

  // Sequencer: clear the valid rows after reset, then fetch a set and resolve.
  always_comb begin
    state_nxt = state_r;
    acc_pop = 1'b0;
    res_valid_nxt = 1'b0;
    res_nxt = res_r;
    hit_nxt = hit_r; miss_nxt = miss_r; evict_nxt = evict_r;
    time_nxt = time_r;
    wr_en = 1'b0; wr_way = victim;
    clr_en = 1'b0; clr_nxt = clr_r;
    case (state_r)
      BK_CLEAR: begin
        clr_en = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == VW'(SETS - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (acc_valid) begin
          acc_pop = 1'b1;
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        time_nxt = time_r + 1'b1;
        res_nxt.extra_hit = 1'b0;
        if (cur_r.instr) begin
          res_nxt.outcome = OUT_IGNORE;
        end else begin
          wr_en = 1'b1;
          if (hit) begin
            wr_way = hit_way;
            res_nxt.outcome = OUT_HIT;
            hit_nxt = sat_inc(hit_nxt);
          end else begin
            miss_nxt = sat_inc(miss_r);
            if (have_empty) begin
              res_nxt.outcome = OUT_FILL;
            end else begin
              res_nxt.outcome = OUT_EVICT;
              evict_nxt = sat_inc(evict_r);
            end
          end
          if (cur_r.modify) begin
            hit_nxt = sat_inc(hit_nxt);
            res_nxt.extra_hit = 1'b1;
          end
        end
        res_nxt.hit_total = hit_nxt;
        res_nxt.miss_total = miss_nxt;
        res_nxt.eviction_total = evict_nxt;
        res_valid_nxt = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r <= '0;
      time_r <= '0;
      hit_r <= '0; miss_r <= '0; evict_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      time_r <= time_nxt;
      hit_r <= hit_nxt; miss_r <= miss_nxt; evict_r <= evict_nxt;
      res_valid_r <= res_valid_nxt;
    end
    res_r <= res_nxt;
    if (acc_pop) cur_r <= acc;
  end

  // Row read in the fetch cycle. Tags and stamps of invalid lines are never
  // used: an invalid way is always chosen before any LRU victim.
  always_ff @(posedge clk) begin
    if (state_r == BK_READ) begin
      tag_rd_r <= tag_mem[set_idx];
      stamp_rd_r <= stamp_mem[set_idx];
      valid_rd_r <= valid_mem[set_idx];
    end
  end

  // Valid rows: cleared one set per cycle after reset, set on every write-back.
  always_ff @(posedge clk) begin
    if (clr_en) begin
      valid_mem[clr_r] <= '0;
    end else if (wr_en) begin
      valid_mem[set_idx][wr_way] <= 1'b1;
    end
  end

  // Line write-back on a hit, fill or eviction.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[set_idx][wr_way] <= cur_r.tag;
      stamp_mem[set_idx][wr_way] <= time_nxt;
    end
  end

  assign busy = (state_r != BK_IDLE) || acc_valid;
  assign res_valid = res_valid_r;
  assign res = res_r;

  // A result follows each resolve cycle.
  a_res_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DECIDE |=> res_valid_r) else $error("missing result");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == BK_DECIDE) else $error("write outside resolve");
  a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> miss_r >= $past(miss_r)) else $error("miss count fell");

endmodule

// ===== rtl/set_assoc_lru_cache_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker: LRU set-associative cache tag tracker.
// Classifies accesses, looks up a set and reports outcome and totals.
// ----------------------------------------------------------------------------
// Each access passes the classifier register, the back part's access
// register, a registered read of the set's row from the tag, stamp and
// valid memories, a compare that chooses a way and writes back, and the
// result register before its out_valid strobe. busy stays high until the
// set has been resolved, so one access is in flight at a time; the
// result strobe lasts one cycle and cannot be stalled. After reset, busy
// stays high while a clearing pass marks every line of all sets invalid.
// Configuration writes are taken only while busy and start are low.
module set_assoc_lru_cache_tracker import salru_pkg::*; #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [2:0] set_bits_r;
  logic [3:0] ways_used_r;
  logic [5:0] offset_bits_r;
  logic acc_valid, acc_pop, bk_busy, take;
  acc_t acc;

  assign cfg_ready = !busy && !start;
  assign busy = bk_busy;
  assign take = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= '0;
      ways_used_r <= 4'd1;
      offset_bits_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SET_BITS:    set_bits_r <= cfg_data[2:0];
        REG_WAYS_USED:   ways_used_r <= cfg_data[3:0];
        REG_OFFSET_BITS: offset_bits_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  salru_front #(.SET_W(MAX_SET_BITS)) u_front (
    .clk, .rst_n, .take, .item(in_item), .set_bits(set_bits_r),
    .offset_bits(offset_bits_r), .acc_valid, .acc, .acc_pop
  );

  salru_back #(.SET_W(MAX_SET_BITS), .WAYS(MAX_WAYS)) u_back (
    .clk, .rst_n, .ways_used(ways_used_r), .acc_valid, .acc, .acc_pop,
    .busy(bk_busy), .res_valid(out_valid), .res(out_item)
  );

endmodule

// ===== tb/set_assoc_lru_cache_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_tb: self-checking bench of the LRU tag tracker.
// Drives directed and random access streams under several register settings.
// Each result is checked against a shadow cache model kept in the bench.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker_tb;
  import salru_pkg::*;

  localparam int SETS_MAX  = 6;
  localparam int WAYS_MAX  = 8;
  localparam int LINES     = (1 << SETS_MAX) * WAYS_MAX;
  localparam int IDLE_LIMIT = 1000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Shadow cache state and register copies.
  logic             line_live [LINES];
  logic [63:0]      line_tag_sh [LINES];
  logic [63:0]      line_stamp_sh [LINES];
  logic [63:0]      clock_now;
  logic [CNT_W-1:0] hits_sh;
  logic [CNT_W-1:0] misses_sh;
  logic [CNT_W-1:0] evicts_sh;
  logic [2:0]       set_bits_sh;
  logic [3:0]       ways_sh;
  logic [5:0]       offset_sh;

  out_item_t pending_results[$];
  int        mismatches;
  int        quiet_cycles;
  bit        steady;

  set_assoc_lru_cache_tracker dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Looks up one access in the shadow cache and returns the expected result.
  function automatic out_item_t lookup_access(input in_item_t it);
    out_item_t   r;
    int          sb, nw, base, empty_way, lru_way, victim;
    bit          have_empty, hit;
    logic [63:0] tg, st, lru_stamp;
    r = '0;
    clock_now = clock_now + 1;
    r.outcome = OUT_IGNORE;
    if (it.mode != MODE_INSTR) begin
      sb = (set_bits_sh > SETS_MAX) ? SETS_MAX : set_bits_sh;
      nw = (ways_sh == 0) ? 1 : ((ways_sh > WAYS_MAX) ? WAYS_MAX : ways_sh);
      tg = (offset_sh + sb >= 64) ? 64'd0 : (it.address >> (offset_sh + sb));
      st = (it.address >> offset_sh) & ((64'd1 << sb) - 1);
      base = int'(st) * WAYS_MAX;
      have_empty = 0;
      hit = 0;
      empty_way = 0;
      lru_way = 0;
      lru_stamp = '0;
      for (int w = 0; w < nw && !hit; w++) begin
        if (line_live[base + w] && line_tag_sh[base + w] == tg) begin
          line_stamp_sh[base + w] = clock_now;
          hits_sh = bump(hits_sh);
          r.outcome = OUT_HIT;
          hit = 1;
        end else begin
          if (!line_live[base + w]) begin
            have_empty = 1;
            empty_way = w;
          end
          if (w == 0 || line_stamp_sh[base + w] < lru_stamp) begin
            lru_stamp = line_stamp_sh[base + w];
            lru_way = w;
          end
        end
      end
      if (!hit) begin
        misses_sh = bump(misses_sh);
        victim = base + (have_empty ? empty_way : lru_way);
        line_tag_sh[victim] = tg;
        line_live[victim] = 1'b1;
        line_stamp_sh[victim] = clock_now;
        if (have_empty) begin
          r.outcome = OUT_FILL;
        end else begin
          evicts_sh = bump(evicts_sh);
          r.outcome = OUT_EVICT;
        end
      end
      if (it.mode == MODE_MODIFY) begin
        hits_sh = bump(hits_sh);
        r.extra_hit = 1'b1;
      end
    end
    r.hit_total = hits_sh;
    r.miss_total = misses_sh;
    r.eviction_total = evicts_sh;
    return r;
  endfunction

  // Sends one access; start stays high after the transfer for the next call.
  task automatic send_access(input mode_t m, input logic [63:0] addr);
    in_item_t it;
    it.mode = m;
    it.address = addr;
    if (!steady && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(lookup_access(it));
  endtask

  // Writes one register once every result has come back.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SET_BITS:  set_bits_sh = val[2:0];
      REG_WAYS_USED: ways_sh = val[3:0];
      default:       offset_sh = val[5:0];
    endcase
  endtask

  // Builds an address from a small tag pool so sets fill, hit and evict.
  function automatic logic [63:0] pooled_address();
    int sb;
    sb = (set_bits_sh > SETS_MAX) ? SETS_MAX : set_bits_sh;
    return ((64'($urandom_range(0, 11)) << (offset_sh + sb)) |
            (64'($urandom) << offset_sh) & ~(64'hFFFF_FFFF_FFFF_FFFF << (offset_sh + sb)))
           | (64'({$urandom, $urandom}) & ~(64'hFFFF_FFFF_FFFF_FFFF << offset_sh));
  endfunction

  task automatic test_defaults();
    send_access(MODE_INSTR, 64'd0);
    send_access(MODE_LOAD, 64'd0);
    send_access(MODE_LOAD, 64'd0);
    send_access(MODE_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(MODE_STORE, 64'd0);
    send_access(MODE_MODIFY, 64'h8000_0000_0000_0001);
    send_access(MODE_INSTR, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Oversized set bits, out-of-range ways and a split that leaves no tag.
  task automatic test_register_extremes();
    write_reg(REG_SET_BITS, 8'hFF);
    write_reg(REG_WAYS_USED, 8'hFF);
    write_reg(REG_OFFSET_BITS, 8'hFF);
    send_access(MODE_LOAD, 64'h1234_5678_9ABC_DEF0);
    send_access(MODE_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(MODE_MODIFY, 64'h0);
    write_reg(REG_OFFSET_BITS, 8'd58);
    write_reg(REG_SET_BITS, 8'd6);
    send_access(MODE_LOAD, 64'hFC00_0000_0000_0000);
    send_access(MODE_LOAD, 64'h0400_0000_0000_0000);
    write_reg(REG_WAYS_USED, 8'd0);
    write_reg(REG_SET_BITS, 8'd0);
    write_reg(REG_OFFSET_BITS, 8'd0);
    send_access(MODE_LOAD, 64'h5);
    send_access(MODE_LOAD, 64'h6);
    send_access(MODE_MODIFY, 64'h6);
  endtask

  // Random streams over several settings, one stretch without any gaps.
  task automatic test_random_streams();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SET_BITS, 8'd2);
          write_reg(REG_WAYS_USED, 8'd4);
          write_reg(REG_OFFSET_BITS, 8'd4);
        end
        1: begin
          write_reg(REG_SET_BITS, 8'd0);
          write_reg(REG_WAYS_USED, 8'd8);
          write_reg(REG_OFFSET_BITS, 8'd0);
        end
        2: write_reg(REG_WAYS_USED, 8'd1);
        3: begin
          write_reg(REG_SET_BITS, 8'd6);
          write_reg(REG_WAYS_USED, 8'd2);
          write_reg(REG_OFFSET_BITS, 8'd58);
        end
        default: begin
          write_reg(REG_SET_BITS, CFG_DAT_W'($urandom));
          write_reg(REG_WAYS_USED, CFG_DAT_W'($urandom));
          write_reg(REG_OFFSET_BITS, CFG_DAT_W'($urandom_range(0, 40)));
        end
      endcase
      steady = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          send_access(mode_t'($urandom_range(0, 2)), pooled_address());
        end else begin
          send_access(mode_t'($urandom_range(0, 3)), {$urandom, $urandom});
        end
      end
      steady = 0;
    end
  endtask

  // Checks each result strobe against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.outcome !== want.outcome || out_item.extra_hit !== want.extra_hit ||
            out_item.hit_total !== want.hit_total ||
            out_item.miss_total !== want.miss_total ||
            out_item.eviction_total !== want.eviction_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h, got %h", want, out_item);
        end
      end
    end
  end

  // Watchdog on cycles that move no transfer.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("set_assoc_lru_cache_tracker_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    steady = 0;
    for (int i = 0; i < LINES; i++) begin
      line_live[i] = 1'b0;
      line_tag_sh[i] = '0;
      line_stamp_sh[i] = '0;
    end
    clock_now = '0;
    hits_sh = '0;
    misses_sh = '0;
    evicts_sh = '0;
    set_bits_sh = '0;
    ways_sh = 4'd1;
    offset_sh = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_register_extremes();
    test_random_streams();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("set_assoc_lru_cache_tracker_tb passed");
    end else begin
      $display("set_assoc_lru_cache_tracker_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/salru_pkg.sv
rtl/salru_front.sv
rtl/salru_back.sv
rtl/set_assoc_lru_cache_tracker.sv
tb/set_assoc_lru_cache_tracker_tb.sv
